FILE: sv/cfhd_pkg.sv
// package: constants, coefficient table and shared types for the decimator
package cfhd_pkg;
    localparam int MAX_STAGES_DEF   = 8;
    localparam int TAP_COUNT        = 128;
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COEF_WIDTH_DEF   = 18;
    localparam int HIST_LEN         = TAP_COUNT - 1;
    localparam int HALF_TAPS        = 64;
    localparam int TABLE_FRAC       = 24;
    localparam int PTR_W            = 7;
    localparam int TAP_W            = 7;

    typedef enum logic [2:0] {
        S_IDLE, S_PRIME, S_MAC, S_DRAIN, S_DONE, S_OUT
    } t_state;

    typedef logic signed [25:0] t_q24;

    function automatic t_q24 half_tap(input logic [5:0] h);
        case (h)
            6'd0: half_tap = 26'sd109;       6'd1: half_tap = 26'sd624;
            6'd2: half_tap = 26'sd1507;      6'd3: half_tap = 26'sd1854;
            6'd4: half_tap = 26'sd660;       6'd5: half_tap = -26'sd1326;
            6'd6: half_tap = -26'sd1571;     6'd7: half_tap = 26'sd828;
            6'd8: half_tap = 26'sd2623;      6'd9: half_tap = 26'sd312;
            6'd10: half_tap = -26'sd3496;    6'd11: half_tap = -26'sd2306;
            6'd12: half_tap = 26'sd3635;     6'd13: half_tap = 26'sd5025;
            6'd14: half_tap = -26'sd2443;    6'd15: half_tap = -26'sd7987;
            6'd16: half_tap = -26'sd558;     6'd17: half_tap = 26'sd10363;
            6'd18: half_tap = 26'sd5539;     6'd19: half_tap = -26'sd11056;
            6'd20: half_tap = -26'sd12182;   6'd21: half_tap = 26'sd8893;
            6'd22: half_tap = 26'sd19551;    6'd23: half_tap = -26'sd2892;
            6'd24: half_tap = -26'sd26068;   6'd25: half_tap = -26'sd7401;
            6'd26: half_tap = 26'sd29649;    6'd27: half_tap = 26'sd21598;
            6'd28: half_tap = -26'sd27984;   6'd29: half_tap = -26'sd38228;
            6'd30: half_tap = 26'sd18985;    6'd31: half_tap = 26'sd54657;
            6'd32: half_tap = -26'sd1311;    6'd33: half_tap = -26'sd67227;
            6'd34: half_tap = -26'sd25078;   6'd35: half_tap = 26'sd71646;
            6'd36: half_tap = 26'sd58481;    6'd37: half_tap = -26'sd63595;
            6'd38: half_tap = -26'sd95194;   6'd39: half_tap = 26'sd39512;
            6'd40: half_tap = 26'sd129538;   6'd41: half_tap = 26'sd2564;
            6'd42: half_tap = -26'sd154200;  6'd43: half_tap = -26'sd62217;
            6'd44: half_tap = 26'sd160872;   6'd45: half_tap = 26'sd136059;
            6'd46: half_tap = -26'sd141093;  6'd47: half_tap = -26'sd217430;
            6'd48: half_tap = 26'sd87126;    6'd49: half_tap = 26'sd296367;
            6'd50: half_tap = 26'sd7389;     6'd51: half_tap = -26'sd359735;
            6'd52: half_tap = -26'sd147411;  6'd53: half_tap = 26'sd391075;
            6'd54: half_tap = 26'sd337885;   6'd55: half_tap = -26'sd368961;
            6'd56: half_tap = -26'sd588595;  6'd57: half_tap = 26'sd259967;
            6'd58: half_tap = 26'sd930010;   6'd59: half_tap = 26'sd10750;
            6'd60: half_tap = -26'sd1482381; 6'd61: half_tap = -26'sd736298;
            6'd62: half_tap = 26'sd3069677;  6'd63: half_tap = 26'sd6869503;
            default: half_tap = '0;
        endcase
    endfunction
endpackage

FILE: sv/cascaded_fir_halfband_decimator_unit.sv
// top level of the cascaded decimate-by-two fir
// channel | dir | fields (lsb up)
// s_axis  | in  | tdata: in_sample[23:0]; tuser: series_start
// m_axis  | out | tdata: out_sample[23:0]
// cfg     | in  | stage_count[3:0] via write enable
// a stage that fires runs all its taps on the shared mac; one that skips only stores its sample
// priming a stage fills its history with 127 writes of the incoming sample
// an item is taken only in idle, and no new one is taken until it is through every stage it reaches
// a result then passes the output state and waits there while the previous result is still held
// reset is synchronous, active low; history ram needs no clearing
module cascaded_fir_halfband_decimator_unit #(
    parameter int MAX_STAGES   = cfhd_pkg::MAX_STAGES_DEF,
    parameter int SAMPLE_WIDTH = cfhd_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = cfhd_pkg::COEF_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [3:0]              i_cfg_wdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [SAMPLE_WIDTH-1:0] s_axis_tdata,   // in_sample
    input  logic                    s_axis_tuser,   // series_start
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [SAMPLE_WIDTH-1:0] m_axis_tdata    // out_sample
);
    import cfhd_pkg::*;

    logic [3:0] r_stage_count;
    logic q_valid, q_ready, q_start;
    logic [SAMPLE_WIDTH-1:0] q_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_stage_count <= 4'd1;
        else if (i_cfg_we) r_stage_count <= i_cfg_wdata;
    end

    cfhd_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_sample(s_axis_tdata), .i_start(s_axis_tuser),
        .o_valid(q_valid), .i_ready(q_ready), .o_sample(q_sample), .o_start(q_start)
    );

    cfhd_back #(.MAX_STAGES(MAX_STAGES), .SAMPLE_WIDTH(SAMPLE_WIDTH),
                .COEF_WIDTH(COEF_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_stage_count(r_stage_count),
        .i_valid(q_valid), .o_ready(q_ready), .i_sample(q_sample), .i_start(q_start),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_sample(m_axis_tdata)
    );
endmodule

FILE: sv/cfhd_ram.sv
// generic single-port-write ram with registered read
module cfhd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1016
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sv/cfhd_front.sv
// front end: input acceptance and two-entry queue of samples with series flag
module cfhd_front #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_start,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [SAMPLE_WIDTH-1:0] o_sample,
    output logic                    o_start
);
    logic [SAMPLE_WIDTH:0] r_q [2];
    logic                  r_wp, r_rp;
    logic [1:0]            r_cnt, n_cnt;
    logic                  w_push, w_pop;

    assign o_ready  = (r_cnt != 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign w_push   = i_valid && o_ready;
    assign w_pop    = o_valid && i_ready;
    assign o_sample = r_q[r_rp][SAMPLE_WIDTH-1:0];
    assign o_start  = r_q[r_rp][SAMPLE_WIDTH];

    always_comb begin
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
        end
        if (w_push) r_q[r_wp] <= {i_start, i_sample};
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !w_pop) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count not advanced");
endmodule

FILE: sv/cfhd_back.sv
// back end: stage sequencer with one shared multiply-accumulate over the history ram
module cfhd_back #(
    parameter int MAX_STAGES   = 8,
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 18
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [3:0]              i_stage_count,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_start,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [SAMPLE_WIDTH-1:0] o_sample
);
    import cfhd_pkg::*;

    localparam int SW     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int DEPTH  = MAX_STAGES * HIST_LEN;
    localparam int AW     = $clog2(DEPTH);
    localparam int FR     = COEF_WIDTH - 1;
    localparam int SH     = TABLE_FRAC - FR;
    localparam int ACC_W  = SAMPLE_WIDTH + COEF_WIDTH + 8;

    t_state r_state, n_state;
    logic [SW-1:0]  r_k;
    logic [SW:0]    w_n;
    logic [PTR_W-1:0] r_ptr   [MAX_STAGES];
    logic [MAX_STAGES-1:0] r_phase, r_primed;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic [TAP_W-1:0] r_j;
    logic [PTR_W-1:0] r_ra;
    logic r_mv;
    logic [TAP_W-1:0] r_mj;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [SAMPLE_WIDTH-1:0] r_out;
    logic r_ov;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [SAMPLE_WIDTH-1:0] rdata, wdata;

    assign w_n = (i_stage_count == 4'd0) ? (SW+1)'(1) :
                 ({1'b0, i_stage_count} > 5'(MAX_STAGES)) ? (SW+1)'(MAX_STAGES) :
                 (SW+1)'(i_stage_count);

    function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] k,
                                               input logic [PTR_W-1:0] p);
        addr_of = AW'(k) * AW'(HIST_LEN) + AW'(p);
    endfunction

    function automatic logic signed [COEF_WIDTH-1:0] coef(input logic [TAP_W-1:0] j);
        logic [5:0] h;
        logic signed [26:0] c;
        h = j[6] ? ~j[5:0] : j[5:0];
        c = 27'(half_tap(h));
        if (SH > 0) c = (c + (27'sd1 <<< (SH - 1))) >>> SH;
        coef = COEF_WIDTH'(c);
    endfunction

    cfhd_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(DEPTH)) u_hist (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [PTR_W-1:0] w_p, w_pn;
    assign w_p  = r_ptr[r_k];
    assign w_pn = (w_p == PTR_W'(HIST_LEN - 1)) ? '0 : w_p + 1'b1;

    // history read pointer walks oldest to newest
    assign raddr = addr_of(r_k, r_ra);

    always_comb begin
        we    = 1'b0;
        waddr = addr_of(r_k, r_j);
        wdata = r_x;
        case (r_state)
            S_PRIME: we = !r_primed[r_k];
            S_DONE: begin
                we    = 1'b1;
                waddr = addr_of(r_k, w_p);
            end
            default: ;
        endcase
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ov;
    assign o_sample = r_out;

    // shared multiplier: history taps, then the incoming sample on the last tap
    logic w_last;
    logic signed [COEF_WIDTH-1:0] w_ca;
    logic signed [SAMPLE_WIDTH-1:0] w_xa;
    logic signed [SAMPLE_WIDTH+COEF_WIDTH-1:0] w_prod;
    assign w_last = (r_state == S_DRAIN) && !r_mv;
    assign w_ca   = coef(w_last ? TAP_W'(TAP_COUNT - 1) : r_mj);
    assign w_xa   = w_last ? r_x : $signed(rdata);
    assign w_prod = w_ca * w_xa;

    logic signed [ACC_W-1:0] w_rnd;
    logic signed [SAMPLE_WIDTH-1:0] w_sat;
    localparam logic signed [ACC_W-1:0] HI = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH-1)) - 1);
    localparam logic signed [ACC_W-1:0] LO = -ACC_W'(64'sd1 <<< (SAMPLE_WIDTH-1));
    always_comb begin
        w_rnd = (r_acc + (ACC_W'(1) <<< (FR - 1))) >>> FR;
        if (w_rnd > HI) w_sat = SAMPLE_WIDTH'(HI);
        else if (w_rnd < LO) w_sat = SAMPLE_WIDTH'(LO);
        else w_sat = SAMPLE_WIDTH'(w_rnd);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_PRIME;
            S_PRIME: begin
                if (r_primed[r_k] || r_j == TAP_W'(HIST_LEN - 1))
                    n_state = (r_primed[r_k] && r_phase[r_k]) ? S_DONE : S_MAC;
            end
            S_MAC:   if (r_j == TAP_W'(HIST_LEN - 1)) n_state = S_DRAIN;
            S_DRAIN: if (!r_mv) n_state = S_DONE;
            S_DONE: begin
                if (r_phase[r_k]) n_state = S_IDLE;
                else if ((SW+1)'(r_k) + 1'b1 == w_n) n_state = S_OUT;
                else n_state = S_PRIME;
            end
            S_OUT:   if (!r_ov || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= '0;
            r_primed <= '0;
            r_ov     <= 1'b0;
            r_mv     <= 1'b0;
            for (int i = 0; i < MAX_STAGES; i++) r_ptr[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && (!r_ov || i_ready)) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            r_mv <= (r_state == S_MAC);
            r_mj <= r_j;
            if (r_state == S_PRIME) r_acc <= '0;
            else if (r_mv || r_state == S_DRAIN) r_acc <= r_acc + ACC_W'(w_prod);
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_x <= i_sample;
                    r_k <= '0;
                    r_j <= '0;
                    if (i_start) r_primed <= '0;
                end
                S_PRIME: begin
                    if (r_primed[r_k] || r_j == TAP_W'(HIST_LEN - 1)) begin
                        if (!r_primed[r_k]) begin
                            r_primed[r_k] <= 1'b1;
                            r_phase[r_k]  <= 1'b0;
                            r_ptr[r_k]    <= '0;
                            r_ra          <= '0;
                        end else begin
                            r_ra <= w_p;
                        end
                        r_j   <= '0;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_MAC: begin
                    r_j  <= r_j + 1'b1;
                    r_ra <= (r_ra == PTR_W'(HIST_LEN - 1)) ? '0 : r_ra + 1'b1;
                end
                S_DONE: begin
                    r_ptr[r_k]   <= w_pn;
                    r_phase[r_k] <= ~r_phase[r_k];
                    r_j <= '0;
                    if (!r_phase[r_k]) begin
                        r_x <= w_sat;
                        r_k <= r_k + 1'b1;
                    end
                end
                S_OUT: if (!r_ov || i_ready) begin
                    r_out <= r_x;
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> r_primed[r_k]) else $error("filter on unprimed stage");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_phase[r_k]) |-> ((SW+1)'(r_k) < w_n))
        else $error("stage index past stage count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable(r_out))) else $error("result lost");
endmodule

FILE: dv/tb_cascaded_fir_halfband_decimator_unit.sv
// testbench for the cascaded decimate-by-two fir: directed table, then random series per stage count
`timescale 1ns / 100ps

module tb_cascaded_fir_halfband_decimator_unit;
    import cfhd_pkg::*;

    localparam int SW        = SAMPLE_WIDTH_DEF;
    localparam int NSTG      = MAX_STAGES_DEF;
    localparam int FRAC      = COEF_WIDTH_DEF - 1;
    localparam int SETTLE    = 8000;
    localparam int LIMIT     = 10000000;
    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [3:0]    i_cfg_wdata = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [SW-1:0] s_axis_tdata = '0;   // in_sample
    logic          s_axis_tuser = 1'b0; // series_start
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [SW-1:0] m_axis_tdata;        // out_sample

    cascaded_fir_halfband_decimator_unit dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 start;
        logic                 typed;
        logic signed [SW-1:0] out_val;
    } t_row;

    // filter state of the predictor
    longint         fir_hist[NSTG][HIST_LEN];
    int             fir_ptr[NSTG];
    bit             fir_phase[NSTG];
    bit             fir_primed[NSTG];
    logic [3:0]     fir_count;
    longint         fir_coef[TAP_COUNT];

    logic signed [SW-1:0] out_expected[$];
    int  errors = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    longint cycles = 0;

    function automatic longint round_sat(longint acc);
        longint r;
        r = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        if (r > longint'(SMAX)) r = longint'(SMAX);
        if (r < longint'(SMIN)) r = longint'(SMIN);
        return r;
    endfunction

    task automatic decimate_sample(input logic signed [SW-1:0] smp, input logic start,
                                   output bit fired, output logic signed [SW-1:0] y);
        int n;
        longint x, acc;
        int p;
        n = (fir_count == 0) ? 1 : (fir_count > NSTG ? NSTG : fir_count);
        x = smp;
        fired = 1'b0;
        y = '0;
        if (start)
            for (int k = 0; k < NSTG; k++) fir_primed[k] = 1'b0;
        for (int k = 0; k < n; k++) begin
            if (!fir_primed[k]) begin
                for (int j = 0; j < HIST_LEN; j++) fir_hist[k][j] = x;
                fir_ptr[k] = 0;
                fir_phase[k] = 1'b0;
                fir_primed[k] = 1'b1;
            end
            p = fir_ptr[k];
            acc = 0;
            if (fir_phase[k] == 1'b0) begin
                for (int j = 0; j < HIST_LEN; j++)
                    acc += fir_coef[j] * fir_hist[k][(p + j) % HIST_LEN];
                acc += fir_coef[TAP_COUNT-1] * x;
            end
            fir_hist[k][p] = x;
            fir_ptr[k] = (p + 1) % HIST_LEN;
            fir_phase[k] = ~fir_phase[k];
            if (fir_phase[k] == 1'b0) return;
            x = round_sat(acc);
        end
        fired = 1'b1;
        y = x[SW-1:0];
    endtask

    // sender: bursts and gaps, inputs change at the falling edge
    int burst_left = 0;
    task automatic send_sample(input logic signed [SW-1:0] smp, input logic start,
                               input logic typed, input logic signed [SW-1:0] tval);
        bit fired;
        logic signed [SW-1:0] y;
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = smp;
        s_axis_tuser  = start;
        do @(posedge i_clk); while (!s_axis_tready);
        decimate_sample(smp, start, fired, y);
        if (fired) out_expected.push_back(typed ? tval : y);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_and_settle();
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (out_expected.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_count(input logic [3:0] v);
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        fir_count = v;
    endtask

    function automatic logic signed [SW-1:0] pick_sample(int idx);
        case ($urandom_range(0, 5))
            0: return SW'($urandom);
            1: return ($urandom_range(0, 1) != 0) ? SMAX : SMIN;
            2: return ((idx & 1) != 0) ? SMAX : SMIN;
            3: return SW'($urandom_range(0, 4000)) - SW'(2000);
            default: return SW'($urandom) >>> $urandom_range(0, 12);
        endcase
    endfunction

    // receiver stall pattern
    int stall_run = 0;
    bit stall_mode = 1'b0;
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode <= ($urandom_range(0, 2) == 0);
            stall_run  <= $urandom_range(1, 20);
            m_axis_tready <= 1'b1;
        end else begin
            stall_run <= stall_run - 1;
            m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen <= results_seen + 1;
            if (out_expected.size() == 0) begin
                $error("out_sample: no transaction expected, actual %0d",
                       $signed(m_axis_tdata));
                errors <= errors + 1;
            end else begin
                logic signed [SW-1:0] e;
                e = out_expected.pop_front();
                if (e !== m_axis_tdata) begin
                    $error("out_sample: expected %0d, actual %0d", e, $signed(m_axis_tdata));
                    errors <= errors + 1;
                end
            end
        end
    end

    t_row directed[] = '{
        '{'0, 1'b1, 1'b1, '0},
        '{'0, 1'b0, 1'b0, '0},
        '{'0, 1'b0, 1'b1, '0},
        '{SMAX, 1'b1, 1'b0, '0},
        '{SMAX, 1'b0, 1'b0, '0},
        '{SMAX, 1'b0, 1'b0, '0},
        '{SMIN, 1'b1, 1'b0, '0},
        '{SMIN, 1'b0, 1'b0, '0},
        '{SMIN, 1'b0, 1'b0, '0},
        '{SMAX, 1'b0, 1'b0, '0},
        '{SMIN, 1'b0, 1'b0, '0},
        '{SMAX, 1'b0, 1'b0, '0},
        '{SMIN, 1'b0, 1'b0, '0},
        '{SMAX, 1'b0, 1'b0, '0},
        '{-24'sd1, 1'b1, 1'b0, '0},
        '{24'sd1, 1'b0, 1'b0, '0},
        '{24'sh555555, 1'b0, 1'b0, '0},
        '{24'shAAAAAA, 1'b0, 1'b0, '0},
        '{'0, 1'b1, 1'b1, '0},
        '{'0, 1'b0, 1'b0, '0},
        '{'0, 1'b0, 1'b1, '0}
    };

    logic [3:0] count_plan[] = '{4'd2, 4'd3, 4'd8, 4'd1, 4'd0, 4'd15, 4'd4, 4'd2, 4'd1};

    initial begin
        int per_phase;
        for (int j = 0; j < TAP_COUNT; j++) begin
            longint c;
            c = half_tap(6'(j < HALF_TAPS ? j : TAP_COUNT - 1 - j));
            fir_coef[j] = (c + (64'sd1 <<< (TABLE_FRAC - FRAC - 1))) >>> (TABLE_FRAC - FRAC);
        end
        for (int k = 0; k < NSTG; k++) begin
            fir_ptr[k] = 0;
            fir_phase[k] = 1'b0;
            fir_primed[k] = 1'b0;
        end
        fir_count = 4'd1;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed[i])
            send_sample(directed[i].sample, directed[i].start,
                        directed[i].typed, directed[i].out_val);

        per_phase = 1300 / count_plan.size();
        foreach (count_plan[ph]) begin
            drain_and_settle();
            write_count(count_plan[ph]);
            for (int i = 0; i < per_phase; i++)
                send_sample(pick_sample(i),
                            (i == 0) || ($urandom_range(0, 79) == 0), 1'b0, '0);
        end

        drain_and_settle();
        $display("covered %0d input transactions over %0d stage-count settings",
                 items_sent, count_plan.size() + 1);
        $display("checked %0d output transactions, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
